// ===== rtl/flic_pixel_chunk_decoder_assert.svh =====
// Assertion macros used by the checker file
`ifndef FLIC_PIXEL_CHUNK_DECODER_ASSERT_SVH
`define FLIC_PIXEL_CHUNK_DECODER_ASSERT_SVH
// Assert an implication on every clock while out of reset
`define FLIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert an implication whose consequent is checked in the next cycle
`define FLIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/flic_pkg.sv =====
package flic_pkg;
  localparam int unsigned AW = 21;
  localparam logic [AW-1:0] ADDR_MAX = {AW{1'b1}};

  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_DONE    = 4'd1;
  localparam logic [3:0] PH_HA_LO   = 4'd2;
  localparam logic [3:0] PH_HA_HI   = 4'd3;
  localparam logic [3:0] PH_HB_LO   = 4'd4;
  localparam logic [3:0] PH_HB_HI   = 4'd5;
  localparam logic [3:0] PH_ROW_LO  = 4'd6;
  localparam logic [3:0] PH_ROW_HI  = 4'd7;
  localparam logic [3:0] PH_SKIP    = 4'd8;
  localparam logic [3:0] PH_SIZE    = 4'd9;
  localparam logic [3:0] PH_FILL_LO = 4'd10;
  localparam logic [3:0] PH_FILL_HI = 4'd11;
  localparam logic [3:0] PH_LIT_LO  = 4'd12;
  localparam logic [3:0] PH_LIT_HI  = 4'd13;

  localparam logic [1:0] K_BRUN  = 2'd0;
  localparam logic [1:0] K_LC    = 2'd1;
  localparam logic [1:0] K_DELTA = 2'd2;

  localparam logic [1:0] CFG_KIND   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // One write command toward the frame store
  typedef struct packed {
    logic [AW-1:0] addr;
    logic [7:0]    v1;
    logic [7:0]    v2;
    logic [7:0]    run;
    logic          word;
    logic          bad;
    logic          outside;
  } cmd_t;

  // Outcome of opening a line: end of chunk, chosen row, line base
  typedef struct packed {
    logic          fin;
    logic [16:0]   row;
    logic [AW-1:0] base;
  } line_t;
endpackage

// ===== rtl/flic_pixel_chunk_decoder.sv =====
// Each accepted beat's result is registered in the head or skid register.
// Throughput: one byte per cycle while in_ready is high.
// A two-entry output buffer keeps in_ready high while one result waits.
// Reset (rst_n, synchronous, active low) restarts the parse and loads
// registers with kind 0, width 320, height 200.
module flic_pixel_chunk_decoder #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_write_address,
  output logic [7:0]  out_first_value,
  output logic [7:0]  out_second_value,
  output logic [7:0]  out_run_length,
  output logic        out_word_mode,
  output logic        out_bad_run,
  output logic        out_outside_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  localparam int unsigned WW = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT) + 1;

  logic [1:0]  kind_r;
  logic [10:0] width_r, height_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic        step, cmd_vld;
  flic_pkg::cmd_t cmd, head_r, skid_r;
  logic        head_v_r, skid_v_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= flic_pkg::K_BRUN; width_r <= 11'd320; height_r <= 11'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flic_pkg::CFG_KIND:   kind_r <= cfg_data[1:0];
        flic_pkg::CFG_WIDTH:  width_r <= cfg_data;
        flic_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate geometry at the maximum
  assign eff_w = ({21'd0, width_r} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_r);
  assign eff_h = ({21'd0, height_r} > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_r);

  assign in_ready = !skid_v_r;
  assign step = in_valid && in_ready;

  flic_parser #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_parser (
    .clk(clk), .rst_n(rst_n), .step(step), .data_byte(in_data_byte),
    .chunk_start(in_chunk_start), .kind(kind_r), .eff_w(eff_w), .eff_h(eff_h),
    .cmd_vld(cmd_vld), .cmd(cmd)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (!head_v_r || out_ready) begin
        if (skid_v_r) begin
          head_r <= skid_r; head_v_r <= 1'b1; skid_v_r <= 1'b0;
          if (step && cmd_vld) begin skid_r <= cmd; skid_v_r <= 1'b1; end
        end else begin
          head_v_r <= step && cmd_vld; head_r <= cmd;
        end
      end else if (step && cmd_vld) begin
        skid_r <= cmd; skid_v_r <= 1'b1;
      end
    end
  end

  assign out_valid = head_v_r;
  assign out_write_address = head_r.addr;
  assign out_first_value = head_r.v1;
  assign out_second_value = head_r.v2;
  assign out_run_length = head_r.run;
  assign out_word_mode = head_r.word;
  assign out_bad_run = head_r.bad;
  assign out_outside_frame = head_r.outside;
endmodule

// ===== rtl/flic_parser.sv =====
module flic_parser #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [7:0]                   data_byte,
  input  logic                         chunk_start,
  input  logic [1:0]                   kind,
  input  logic [$clog2(MAX_WIDTH):0]   eff_w,
  input  logic [$clog2(MAX_HEIGHT):0]  eff_h,
  output logic                         cmd_vld,
  output flic_pkg::cmd_t               cmd
);
  localparam int unsigned AW = flic_pkg::AW;
  localparam int unsigned WW = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT) + 1;
  localparam int unsigned PW = WW + HW;

  logic [3:0]    phase_r, phase_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [16:0]   row_r, row_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [15:0]   want_r, want_nxt;
  logic [15:0]   done_r, done_nxt;
  logic [16:0]   nrow_r, nrow_nxt;
  logic [15:0]   pkts_r, pkts_nxt;
  logic [7:0]    run_r, run_nxt;
  logic [7:0]    held_r, held_nxt;

  flic_pkg::line_t ln;
  logic [15:0]   w16;
  logic [AW:0]   last_a;
  logic [7:0]    sz;
  logic [AW+1:0] end_a;
  logic [PW-1:0] frame;
  logic          do_pkt, pkt_zero;

  // Open a line: pick the row, check the limits, compute the base
  function automatic flic_pkg::line_t open_line(input logic [16:0] row,
                                                input logic [1:0]  md,
                                                input logic [15:0] done,
                                                input logic [15:0] want,
                                                input logic [16:0] nrow);
    flic_pkg::line_t res;
    logic [16:0]   r;
    logic [PW-1:0] prod;
    r = row;
    if (md != flic_pkg::K_BRUN && r < nrow) r = nrow;
    res.fin = (md != flic_pkg::K_BRUN && done >= want) ||
              (r >= {{(17-HW){1'b0}}, eff_h});
    prod = PW'(r[HW-1:0]) * PW'(eff_w);
    res.row = r;
    res.base = (prod > PW'(flic_pkg::ADDR_MAX)) ? flic_pkg::ADDR_MAX : AW'(prod);
    return res;
  endfunction

  // Advance a pointer, saturating at the top of the address space
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [8:0] n);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(n);
    return s[AW] ? flic_pkg::ADDR_MAX : s[AW-1:0];
  endfunction

  always_comb begin
    phase_nxt = phase_r; mode_nxt = mode_r; row_nxt = row_r; base_nxt = base_r;
    wp_nxt = wp_r; want_nxt = want_r; done_nxt = done_r; nrow_nxt = nrow_r;
    pkts_nxt = pkts_r; run_nxt = run_r; held_nxt = held_r;
    cmd_vld = 1'b0;
    cmd = '0;
    do_pkt = 1'b0;
    ln = '0;
    w16 = {data_byte, held_r};
    last_a = '0;
    sz = data_byte[7] ? 8'(9'd256 - {1'b0, data_byte}) : data_byte;
    if (chunk_start) phase_nxt = flic_pkg::PH_START;
    // Restart the parse on the first beat of a chunk or the first beat after reset
    if (phase_nxt == flic_pkg::PH_START) begin
      mode_nxt = kind; row_nxt = '0; base_nxt = '0; wp_nxt = '0; want_nxt = '0;
      done_nxt = '0; nrow_nxt = '0; pkts_nxt = '0; run_nxt = '0; held_nxt = '0;
      unique case (kind)
        flic_pkg::K_BRUN: begin
          ln = open_line(17'd0, kind, 16'd0, 16'd0, 17'd0);
          if (ln.fin) phase_nxt = flic_pkg::PH_DONE;
          else begin
            row_nxt = ln.row; base_nxt = ln.base; wp_nxt = ln.base;
            phase_nxt = flic_pkg::PH_ROW_LO;
          end
        end
        flic_pkg::K_LC:    phase_nxt = flic_pkg::PH_HA_LO;
        flic_pkg::K_DELTA: phase_nxt = flic_pkg::PH_HB_LO;
        default:           phase_nxt = flic_pkg::PH_DONE;
      endcase
    end
    // Decode this beat in the current phase
    unique case (phase_nxt)
      flic_pkg::PH_HA_LO: begin
        nrow_nxt = {9'd0, data_byte}; phase_nxt = flic_pkg::PH_HA_HI;
      end
      flic_pkg::PH_HA_HI: begin
        nrow_nxt = {1'b0, data_byte, nrow_r[7:0]}; phase_nxt = flic_pkg::PH_HB_LO;
      end
      flic_pkg::PH_HB_LO: begin
        want_nxt = {8'd0, data_byte}; phase_nxt = flic_pkg::PH_HB_HI;
      end
      flic_pkg::PH_HB_HI: begin
        want_nxt = {data_byte, want_r[7:0]}; done_nxt = '0; row_nxt = '0;
        ln = open_line(17'd0, mode_nxt, 16'd0, want_nxt, nrow_nxt);
        if (ln.fin) phase_nxt = flic_pkg::PH_DONE;
        else begin
          row_nxt = ln.row; base_nxt = ln.base; wp_nxt = ln.base;
          phase_nxt = flic_pkg::PH_ROW_LO;
        end
      end
      flic_pkg::PH_ROW_LO: begin
        if (mode_nxt == flic_pkg::K_DELTA) begin
          held_nxt = data_byte; phase_nxt = flic_pkg::PH_ROW_HI;
        end else begin
          if (mode_nxt == flic_pkg::K_LC) done_nxt = done_nxt + 16'd1;
          pkts_nxt = {8'd0, data_byte};
          do_pkt = 1'b1;
        end
      end
      flic_pkg::PH_ROW_HI: begin
        if (w16[15:14] == 2'b11) begin
          nrow_nxt = row_r + 17'(17'h10000 - {1'b0, w16});
          row_nxt = row_r + 17'd1;
          ln = open_line(row_nxt, mode_nxt, done_nxt, want_nxt, nrow_nxt);
          if (ln.fin) phase_nxt = flic_pkg::PH_DONE;
          else begin
            row_nxt = ln.row; base_nxt = ln.base; wp_nxt = ln.base;
            phase_nxt = flic_pkg::PH_ROW_LO;
          end
        end else if (w16[15:14] == 2'b10) begin
          last_a = {1'b0, base_r} +
                   (AW+1)'((eff_w != '0) ? eff_w - WW'(1) : '0);
          cmd_vld = 1'b1;
          cmd.addr = last_a[AW] ? flic_pkg::ADDR_MAX : last_a[AW-1:0];
          cmd.v1 = held_r; cmd.run = 8'd1;
          phase_nxt = flic_pkg::PH_ROW_LO;
        end else begin
          done_nxt = done_r + 16'd1;
          pkts_nxt = w16;
          do_pkt = 1'b1;
        end
      end
      flic_pkg::PH_SKIP: begin
        wp_nxt = advance(wp_r, {1'b0, data_byte}); phase_nxt = flic_pkg::PH_SIZE;
      end
      flic_pkg::PH_SIZE: begin
        if (mode_nxt == flic_pkg::K_BRUN) begin
          if (data_byte == 8'd0) begin
            cmd_vld = 1'b1; cmd.addr = wp_r; cmd.bad = 1'b1;
            phase_nxt = flic_pkg::PH_DONE;
          end else begin
            run_nxt = sz;
            phase_nxt = data_byte[7] ? flic_pkg::PH_LIT_LO : flic_pkg::PH_FILL_LO;
          end
        end else if (data_byte == 8'd0) do_pkt = 1'b1;
        else begin
          run_nxt = sz;
          phase_nxt = data_byte[7] ? flic_pkg::PH_FILL_LO : flic_pkg::PH_LIT_LO;
        end
      end
      flic_pkg::PH_FILL_LO: begin
        if (mode_nxt == flic_pkg::K_DELTA) begin
          held_nxt = data_byte; phase_nxt = flic_pkg::PH_FILL_HI;
        end else begin
          cmd_vld = 1'b1; cmd.addr = wp_r; cmd.v1 = data_byte; cmd.run = run_r;
          wp_nxt = advance(wp_r, {1'b0, run_r}); do_pkt = 1'b1;
        end
      end
      flic_pkg::PH_FILL_HI: begin
        cmd_vld = 1'b1; cmd.addr = wp_r; cmd.v1 = held_r; cmd.v2 = data_byte;
        cmd.run = run_r; cmd.word = 1'b1;
        wp_nxt = advance(wp_r, {run_r, 1'b0}); do_pkt = 1'b1;
      end
      flic_pkg::PH_LIT_LO: begin
        if (mode_nxt == flic_pkg::K_DELTA) begin
          held_nxt = data_byte; phase_nxt = flic_pkg::PH_LIT_HI;
        end else begin
          cmd_vld = 1'b1; cmd.addr = wp_r; cmd.v1 = data_byte; cmd.run = 8'd1;
          wp_nxt = advance(wp_r, 9'd1);
          run_nxt = run_r - 8'd1; do_pkt = (run_nxt == 8'd0);
        end
      end
      flic_pkg::PH_LIT_HI: begin
        cmd_vld = 1'b1; cmd.addr = wp_r; cmd.v1 = held_r; cmd.v2 = data_byte;
        cmd.run = 8'd1; cmd.word = 1'b1;
        wp_nxt = advance(wp_r, 9'd2); phase_nxt = flic_pkg::PH_LIT_LO;
        run_nxt = run_r - 8'd1; do_pkt = (run_nxt == 8'd0);
      end
      flic_pkg::PH_DONE: ;
      default: phase_nxt = flic_pkg::PH_DONE;
    endcase
    // Take the next packet, or advance to the next line
    pkt_zero = (pkts_nxt == 16'd0);
    if (do_pkt) begin
      if (pkt_zero) begin
        row_nxt = row_nxt + 17'd1;
        ln = open_line(row_nxt, mode_nxt, done_nxt, want_nxt, nrow_nxt);
        if (ln.fin) phase_nxt = flic_pkg::PH_DONE;
        else begin
          row_nxt = ln.row; base_nxt = ln.base; wp_nxt = ln.base;
          phase_nxt = flic_pkg::PH_ROW_LO;
        end
      end else begin
        pkts_nxt = pkts_nxt - 16'd1;
        phase_nxt = (mode_nxt == flic_pkg::K_BRUN) ? flic_pkg::PH_SIZE : flic_pkg::PH_SKIP;
      end
    end
    // Flag writes that run past the frame
    frame = PW'(eff_w) * PW'(eff_h);
    end_a = (AW+2)'(cmd.addr) + (AW+2)'(cmd.word ? {cmd.run, 1'b0} : {1'b0, cmd.run});
    cmd.outside = !cmd.bad && (end_a > (AW+2)'(frame));
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= flic_pkg::PH_START; mode_r <= '0; row_r <= '0; base_r <= '0;
      wp_r <= '0; want_r <= '0; done_r <= '0; nrow_r <= '0; pkts_r <= '0;
      run_r <= '0; held_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; mode_r <= mode_nxt; row_r <= row_nxt; base_r <= base_nxt;
      wp_r <= wp_nxt; want_r <= want_nxt; done_r <= done_nxt; nrow_r <= nrow_nxt;
      pkts_r <= pkts_nxt; run_r <= run_nxt; held_r <= held_nxt;
    end
  end
endmodule

// ===== rtl/flic_checker.sv =====
`include "flic_pixel_chunk_decoder_assert.svh"
module flic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_run_length,
  input logic        out_word_mode,
  input logic        out_bad_run,
  input logic        out_outside_frame
);
  // An error beat carries no run
  `FLIC_ASSERT_IMP(a_bad_zero, clk, rst_n, out_valid && out_bad_run,
                   out_run_length == 8'd0 && !out_word_mode && !out_outside_frame)
  // A good beat always writes something
  `FLIC_ASSERT_IMP(a_run_nz, clk, rst_n, out_valid && !out_bad_run, out_run_length != 8'd0)
  // Input stalls only while a result is waiting
  `FLIC_ASSERT_IMP(a_ready, clk, rst_n, !in_ready, out_valid)
  // Stalled result holds
  `FLIC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind flic_pixel_chunk_decoder flic_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_run_length(out_run_length),
  .out_word_mode(out_word_mode), .out_bad_run(out_bad_run),
  .out_outside_frame(out_outside_frame)
);

// ===== sim/flic_pixel_chunk_scoreboard.sv =====
`timescale 1ns / 1ps
module flic_pixel_chunk_scoreboard #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] out_write_address,
  input  logic [7:0]  out_first_value,
  input  logic [7:0]  out_second_value,
  input  logic [7:0]  out_run_length,
  input  logic        out_word_mode,
  input  logic        out_bad_run,
  input  logic        out_outside_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          error_count,
  output int          pending_cmds
);

  // Shadow registers and parser state
  logic [1:0]  kind_reg;
  logic [10:0] width_reg, height_reg;
  logic [3:0]  phase;
  logic [1:0]  latched_kind;
  int unsigned row, base, wptr, lines_goal, lines_seen, skip_row, pkts, run_cnt;
  logic [7:0]  hold;
  flic_pkg::cmd_t cmd_queue[$];

  function automatic int unsigned width_eff();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : 32'(width_reg);
  endfunction

  function automatic int unsigned height_eff();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_reg);
  endfunction

  task automatic step_ptr(input int unsigned n);
    longint unsigned p;
    p = longint'(wptr) + n;
    wptr = (p > 64'(flic_pkg::ADDR_MAX)) ? 32'(flic_pkg::ADDR_MAX) : 32'(p);
  endtask

  task automatic push_cmd(input int unsigned a, input logic [7:0] v1, input logic [7:0] v2,
                          input int unsigned run, input logic word, input logic bad);
    flic_pkg::cmd_t c;
    longint unsigned span;
    span = longint'(run) * (word ? 2 : 1);
    c.addr = a[20:0];
    c.v1 = v1;
    c.v2 = v2;
    c.run = run[7:0];
    c.word = word;
    c.bad = bad;
    c.outside = !bad && (longint'(a) + span > longint'(width_eff()) * height_eff());
    cmd_queue.push_back(c);
  endtask

  task automatic open_line();
    int unsigned r;
    longint unsigned b;
    r = row;
    if (latched_kind != flic_pkg::K_BRUN) begin
      if (lines_seen >= lines_goal) begin
        phase = flic_pkg::PH_DONE;
        return;
      end
      if (r < skip_row) r = skip_row;
    end
    if (r >= height_eff()) begin
      phase = flic_pkg::PH_DONE;
      return;
    end
    row = r;
    b = longint'(r) * width_eff();
    base = (b > 64'(flic_pkg::ADDR_MAX)) ? 32'(flic_pkg::ADDR_MAX) : 32'(b);
    wptr = base;
    phase = flic_pkg::PH_ROW_LO;
  endtask

  task automatic next_packet();
    if (pkts == 0) begin
      row++;
      open_line();
    end else begin
      pkts--;
      phase = (latched_kind == flic_pkg::K_BRUN) ? flic_pkg::PH_SIZE : flic_pkg::PH_SKIP;
    end
  endtask

  task automatic literal_done();
    run_cnt = (run_cnt - 1) & 8'hFF;
    if (run_cnt == 0) next_packet();
  endtask

  // Advance the parser by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic first);
    int unsigned w, a;
    if (first) phase = flic_pkg::PH_START;
    if (phase == flic_pkg::PH_START) begin
      latched_kind = kind_reg;
      row = 0; base = 0; wptr = 0; lines_goal = 0; lines_seen = 0;
      skip_row = 0; pkts = 0; run_cnt = 0; hold = 0;
      case (latched_kind)
        flic_pkg::K_BRUN:  open_line();
        flic_pkg::K_LC:    phase = flic_pkg::PH_HA_LO;
        flic_pkg::K_DELTA: phase = flic_pkg::PH_HB_LO;
        default: phase = flic_pkg::PH_DONE;
      endcase
    end
    case (phase)
      flic_pkg::PH_HA_LO: begin
        skip_row = 32'(b);
        phase = flic_pkg::PH_HA_HI;
      end
      flic_pkg::PH_HA_HI: begin
        skip_row |= 32'(b) << 8;
        phase = flic_pkg::PH_HB_LO;
      end
      flic_pkg::PH_HB_LO: begin
        lines_goal = 32'(b);
        phase = flic_pkg::PH_HB_HI;
      end
      flic_pkg::PH_HB_HI: begin
        lines_goal |= 32'(b) << 8;
        lines_seen = 0;
        row = 0;
        open_line();
      end
      flic_pkg::PH_ROW_LO: begin
        if (latched_kind == flic_pkg::K_DELTA) begin
          hold = b;
          phase = flic_pkg::PH_ROW_HI;
        end else begin
          if (latched_kind == flic_pkg::K_LC) lines_seen = (lines_seen + 1) & 16'hFFFF;
          pkts = 32'(b);
          next_packet();
        end
      end
      flic_pkg::PH_ROW_HI: begin
        w = 32'({b, hold});
        if (w[15:14] == 2'b11) begin
          skip_row = (row + (65536 - w)) & 17'h1FFFF;
          row++;
          open_line();
        end else if (w[15:14] == 2'b10) begin
          a = base + ((width_eff() != 0) ? width_eff() - 1 : 0);
          if (a > flic_pkg::ADDR_MAX) a = 32'(flic_pkg::ADDR_MAX);
          push_cmd(a, hold, 8'd0, 1, 1'b0, 1'b0);
          phase = flic_pkg::PH_ROW_LO;
        end else begin
          lines_seen = (lines_seen + 1) & 16'hFFFF;
          pkts = w;
          next_packet();
        end
      end
      flic_pkg::PH_SKIP: begin
        step_ptr(32'(b));
        phase = flic_pkg::PH_SIZE;
      end
      flic_pkg::PH_SIZE: begin
        w = (b >= 128) ? 256 - b : 32'(b);
        if (latched_kind == flic_pkg::K_BRUN) begin
          if (b == 0) begin
            push_cmd(wptr, 8'd0, 8'd0, 0, 1'b0, 1'b1);
            phase = flic_pkg::PH_DONE;
          end else begin
            run_cnt = w;
            phase = (b < 128) ? flic_pkg::PH_FILL_LO : flic_pkg::PH_LIT_LO;
          end
        end else if (b == 0) begin
          next_packet();
        end else begin
          run_cnt = w;
          phase = (b < 128) ? flic_pkg::PH_LIT_LO : flic_pkg::PH_FILL_LO;
        end
      end
      flic_pkg::PH_FILL_LO: begin
        if (latched_kind == flic_pkg::K_DELTA) begin
          hold = b;
          phase = flic_pkg::PH_FILL_HI;
        end else begin
          push_cmd(wptr, b, 8'd0, run_cnt, 1'b0, 1'b0);
          step_ptr(run_cnt);
          next_packet();
        end
      end
      flic_pkg::PH_FILL_HI: begin
        push_cmd(wptr, hold, b, run_cnt, 1'b1, 1'b0);
        step_ptr(2 * run_cnt);
        next_packet();
      end
      flic_pkg::PH_LIT_LO: begin
        if (latched_kind == flic_pkg::K_DELTA) begin
          hold = b;
          phase = flic_pkg::PH_LIT_HI;
        end else begin
          push_cmd(wptr, b, 8'd0, 1, 1'b0, 1'b0);
          step_ptr(1);
          literal_done();
        end
      end
      flic_pkg::PH_LIT_HI: begin
        push_cmd(wptr, hold, b, 1, 1'b1, 1'b0);
        step_ptr(2);
        phase = flic_pkg::PH_LIT_LO;
        literal_done();
      end
      default: phase = flic_pkg::PH_DONE;
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare one result beat with the oldest expected command
  task automatic check_cmd();
    flic_pkg::cmd_t e;
    if (cmd_queue.size() == 0) begin
      $display("%0t unexpected result beat at address %0h", $realtime, out_write_address);
      error_count++;
      return;
    end
    e = cmd_queue.pop_front();
    if (out_write_address !== e.addr) report_mismatch("write_address", out_write_address, e.addr);
    if (out_first_value !== e.v1) report_mismatch("first_value", out_first_value, e.v1);
    if (out_second_value !== e.v2) report_mismatch("second_value", out_second_value, e.v2);
    if (out_run_length !== e.run) report_mismatch("run_length", out_run_length, e.run);
    if (out_word_mode !== e.word) report_mismatch("word_mode", out_word_mode, e.word);
    if (out_bad_run !== e.bad) report_mismatch("bad_run", out_bad_run, e.bad);
    if (out_outside_frame !== e.outside)
      report_mismatch("outside_frame", out_outside_frame, e.outside);
  endtask

  initial begin
    error_count = 0;
    pending_cmds = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 11'd320;
      height_reg = 11'd200;
      kind_reg = flic_pkg::K_BRUN;
      phase = flic_pkg::PH_START;
      latched_kind = flic_pkg::K_BRUN;
      row = 0; base = 0; wptr = 0; lines_goal = 0; lines_seen = 0;
      skip_row = 0; pkts = 0; run_cnt = 0; hold = 0;
      cmd_queue.delete();
    end else begin
      if (out_valid && out_ready) check_cmd();
      if (in_valid && in_ready) decode_byte(in_data_byte, in_chunk_start);
      if (cfg_we) begin
        case (cfg_index)
          flic_pkg::CFG_KIND:   kind_reg = cfg_data[1:0];
          flic_pkg::CFG_WIDTH:  width_reg = cfg_data;
          flic_pkg::CFG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending_cmds = cmd_queue.size();
  end

endmodule

// ===== sim/flic_pixel_chunk_decoder_test.sv =====
`timescale 1ns / 1ps
module flic_pixel_chunk_decoder_test;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_chunk_start;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic [20:0] out_write_address;
  logic [7:0]  out_first_value, out_second_value, out_run_length;
  logic        out_word_mode, out_bad_run, out_outside_frame;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  int          error_count, pending_cmds;
  int          gap_left, burst_left;
  logic [7:0]  body[$];

  flic_pixel_chunk_decoder dut (.*);
  flic_pixel_chunk_scoreboard scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("flic_pixel_chunk_decoder_test: errors");
    $finish;
  end

  // Stall the result side on its own pattern, with calm stretches
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) < 3) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Drop the input and let every expected result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cmds != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Send one byte; bursts and gaps fall at random
  task automatic send_byte(input logic [7:0] b, input logic first);
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 20);
    end
    if (gap_left != 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
    end
    gap_left = 0;
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_chunk_start <= first;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_chunk();
    foreach (body[k]) send_byte(body[k], k == 0);
    body.delete();
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a mostly well-formed chunk body for the given kind
  task automatic build_chunk(input logic [1:0] kind, input int lines);
    int n, p, s;
    logic [15:0] w;
    if (kind == flic_pkg::K_LC) begin
      w = 16'($urandom_range(0, 3));
      body.push_back(w[7:0]); body.push_back(w[15:8]);
    end
    if (kind != flic_pkg::K_BRUN) begin
      w = ($urandom_range(0, 9) == 0) ? 16'(rnd8()) << 8 : 16'(lines);
      body.push_back(w[7:0]); body.push_back(w[15:8]);
    end
    repeat (lines) begin
      if (kind == flic_pkg::K_DELTA) begin
        if ($urandom_range(0, 4) == 0) begin
          w = 16'hC000 | 16'($urandom_range(0, 16383));
          if ($urandom_range(0, 1)) w = 16'hFFFF - 16'($urandom_range(0, 2));
          body.push_back(w[7:0]); body.push_back(w[15:8]);
        end
        if ($urandom_range(0, 4) == 0) begin
          body.push_back(rnd8()); body.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        n = $urandom_range(0, 3);
        body.push_back(8'(n)); body.push_back(($urandom_range(0, 19) == 0) ? 8'h3F : 8'h00);
      end else begin
        n = $urandom_range(0, 3);
        body.push_back(8'(n));
      end
      repeat (n) begin
        if (kind != flic_pkg::K_BRUN) body.push_back(rnd8());
        s = $urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : $urandom_range(1, 128);
        p = $urandom_range(0, 1);
        if (kind == flic_pkg::K_BRUN && $urandom_range(0, 40) == 0) begin
          body.push_back(8'd0);
        end else if (p) begin
          // fill packet
          if (kind == flic_pkg::K_BRUN) body.push_back(8'(s > 127 ? 127 : s));
          else body.push_back(8'(256 - s));
          repeat (kind == flic_pkg::K_DELTA ? 2 : 1) body.push_back(rnd8());
        end else begin
          // literal packet
          if (s > 6 && $urandom_range(0, 3) != 0) s = $urandom_range(1, 6);
          if (kind == flic_pkg::K_BRUN) body.push_back(8'(256 - s));
          else body.push_back(($urandom_range(0, 15) == 0) ? 8'd0 : 8'(s));
          repeat (s * (kind == flic_pkg::K_DELTA ? 2 : 1)) body.push_back(rnd8());
        end
      end
    end
    repeat ($urandom_range(0, 2)) body.push_back(rnd8());
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'd0;
    in_chunk_start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = flic_pkg::CFG_KIND;
    cfg_data = 11'd0;
    burst_left = 0;
    gap_left = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: first byte with no start flag, BRUN fill, then a literal run
    send_byte(8'd1, 1'b0);
    send_byte(8'd127, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hA5, 1'b0);
    send_byte(8'd0, 1'b0); send_byte(8'h55, 1'b0);
    wait_idle();
    // Tiny frame so writes run past it
    write_reg(flic_pkg::CFG_WIDTH, 11'd1);
    write_reg(flic_pkg::CFG_HEIGHT, 11'd1);
    body = '{8'd1, 8'd5, 8'd7, 8'd1};
    send_chunk();
    wait_idle();
    // Line compressed with skip, fill and literal; saturated sizes
    write_reg(flic_pkg::CFG_KIND, 11'(flic_pkg::K_LC));
    write_reg(flic_pkg::CFG_WIDTH, 11'h7FF);
    write_reg(flic_pkg::CFG_HEIGHT, 11'h7FF);
    body = '{8'd2, 8'd0, 8'd1, 8'd0, 8'd2, 8'd255, 8'd128, 8'hC3, 8'd0, 8'd1, 8'd9};
    send_chunk();
    wait_idle();
    // Word delta: skip lines, last-pixel op with width 0, word fill and literal
    write_reg(flic_pkg::CFG_KIND, 11'(flic_pkg::K_DELTA));
    write_reg(flic_pkg::CFG_WIDTH, 11'd0);
    body = '{8'd2, 8'd0, 8'hFE, 8'hFF, 8'h77, 8'h80, 8'd1, 8'd0, 8'd3, 8'hFE,
             8'h12, 8'h34, 8'd1, 8'd0, 8'd0, 8'd1, 8'd1, 8'hAB, 8'hCD};
    send_chunk();
    wait_idle();
    // Kind 3 and height 0 ignore everything
    write_reg(flic_pkg::CFG_KIND, 11'd3);
    body = '{8'd1, 8'd1, 8'd1};
    send_chunk();
    wait_idle();
    write_reg(flic_pkg::CFG_KIND, 11'(flic_pkg::K_BRUN));
    write_reg(flic_pkg::CFG_HEIGHT, 11'd0);
    body = '{8'd1, 8'd1, 8'd1};
    send_chunk();
    wait_idle();

    // Random phases over kinds and frame sizes
    sent = 0;
    while (sent < 1500) begin
      logic [1:0] kind;
      kind = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      write_reg(flic_pkg::CFG_KIND, 11'(kind));
      case ($urandom_range(0, 4))
        0: write_reg(flic_pkg::CFG_WIDTH, 11'd1);
        1: write_reg(flic_pkg::CFG_WIDTH, 11'h7FF);
        default: write_reg(flic_pkg::CFG_WIDTH, 11'($urandom_range(1, 64)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(flic_pkg::CFG_HEIGHT, 11'd1);
        1: write_reg(flic_pkg::CFG_HEIGHT, 11'h7FF);
        default: write_reg(flic_pkg::CFG_HEIGHT, 11'($urandom_range(1, 12)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        build_chunk(kind, $urandom_range(1, 6));
        if ($urandom_range(0, 9) == 0) body[$urandom_range(0, body.size() - 1)] = rnd8();
        sent += body.size();
        send_chunk();
      end
      wait_idle();
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (error_count == 0 && pending_cmds == 0) begin
      $display("flic_pixel_chunk_decoder_test: clean");
    end else begin
      $display("flic_pixel_chunk_decoder_test: errors");
    end
    $finish;
  end

endmodule

// ===== flic_pixel_chunk_decoder.f =====
+incdir+rtl
rtl/flic_pkg.sv
rtl/flic_parser.sv
rtl/flic_pixel_chunk_decoder.sv
rtl/flic_checker.sv
sim/flic_pixel_chunk_scoreboard.sv
sim/flic_pixel_chunk_decoder_test.sv
